/* src/dtrie_pkg.sv */
// ----------------------------------------------------------------------------
// dtrie_pkg
// Shared types, codes and helpers for the nucleotide trie block.
// ----------------------------------------------------------------------------
package dtrie_pkg;

  // Operation selector codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  // Sequence mode
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // ASCII bases
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] base_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [1:0]  status;
    logic [16:0] nodes_used;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_code_t;

  // Map an ASCII base onto its two-bit child slot.
  function automatic base_code_t base_code(input logic [7:0] ch);
    base_code_t r;
    r.valid = 1'b1;
    r.code  = 2'd0;
    case (ch)
      CHAR_A: r.code = 2'd0;
      CHAR_C: r.code = 2'd1;
      CHAR_G: r.code = 2'd2;
      CHAR_T: r.code = 2'd3;
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

  // Index of the lowest set bit of a three-bit mask (2 for an empty mask).
  function automatic logic [1:0] first_set(input logic [2:0] m);
    logic [1:0] r;
    if (m[0]) begin
      r = 2'd0;
    end else if (m[1]) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

endpackage

/* src/dtrie_ram.sv */
// ----------------------------------------------------------------------------
// dtrie_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dtrie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/dna_trie_insert_and_fuzzy_search.sv */
// ----------------------------------------------------------------------------
// dna_trie_insert_and_fuzzy_search
// Four-way nucleotide trie: insert sequences base by base, search them
// exactly or with one substituted base.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_ready  | in_item  (func, base_char, last)
//  out     | output    | out_valid / out_ready| out_item (found, status, nodes_used)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (mismatch allowance)
//
//  Steps: a base on an exact walk reads and evaluates its node, then a
//  finish state takes the next base. Allocating a node under a non-root
//  parent clears the new node, then writes back the parent. A search past
//  its substitution reads its live branches one by one. Skipped bases go
//  straight to the finish state; clears and ignored items return to idle.
//  The node store has a single read port, which sets this order of reads.
//  Reset clears the root links, the allocation count and all walk state;
//  other node entries are written when allocated, so no clearing pass.
//  A result that waits on out_ready holds the block only when the next
//  result is due; the output register otherwise lets input flow on.
//
module dna_trie_insert_and_fuzzy_search
  import dtrie_pkg::*;
#(
  parameter int NODES = 65536
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  localparam int AW = $clog2(NODES);     // node index width
  localparam int CW = $clog2(NODES + 1); // allocation count width

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INS    = 6'b000010,
    S_INS_WR = 6'b000100,
    S_SRCH   = 6'b001000,
    S_BR     = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  // Control state
  state_t                state, state_next;
  logic [AW-1:0]         walk, walk_next;
  logic [2:0][AW-1:0]    branch, branch_next;
  logic [2:0]            alive, alive_next;
  logic [2:0]            pending, pending_next;
  logic                  mismatch, mismatch_next;
  logic                  in_seq, in_seq_next;
  logic                  seq_mode, seq_mode_next;
  logic [1:0]            err, err_next;
  logic [CW-1:0]         free_index, free_index_next;
  logic [3:0][AW-1:0]    root_links, root_links_next;
  logic                  allowance;
  logic                  out_valid_next;

  // Payload registers
  logic [1:0]            code_q, code_next;
  logic                  last_q, last_next;
  logic [1:0]            cur_k, cur_k_next;
  logic [3:0][AW-1:0]    parent_links, parent_links_next;
  logic [AW-1:0]         parent_addr, parent_addr_next;
  out_item_t             out_item_next;

  // Node store port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [4*AW-1:0]       ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [4*AW-1:0]       ram_rdata;

  // Working signals
  logic [3:0][AW-1:0]    rd_links;
  logic [3:0][AW-1:0]    links;
  logic [AW-1:0]         child;
  logic                  fin_fire;
  logic                  in_fire;
  base_code_t            bc;
  logic                  seq_open;
  logic                  mode_eff;
  logic [AW-1:0]         walk_eff;
  logic                  mism_eff;
  logic [2:0]            alive_eff;
  logic [1:0]            err_eff;
  logic [1:0]            sel;
  logic [1:0]            kk;
  logic [CW+16:0]        nodes_wide;
  logic                  found_now;

  dtrie_ram #(
    .WIDTH(4 * AW),
    .DEPTH(NODES)
  ) u_node_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_links   = ram_rdata;
  // The root lives in flops; every other node comes from the store.
  assign links      = (walk == '0) ? root_links : rd_links;
  assign child      = links[code_q];
  assign cfg_ready  = 1'b1;
  assign nodes_wide = {17'd0, free_index};
  assign found_now  = (seq_mode == MODE_SEARCH) && (err == STATUS_OK) &&
                      (!mismatch || (alive != 3'b000));
  assign bc         = base_code(in_item.base_char);
  assign in_ready   = (state == S_IDLE) || fin_fire;
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    state_next        = state;
    walk_next         = walk;
    branch_next       = branch;
    alive_next        = alive;
    pending_next      = pending;
    mismatch_next     = mismatch;
    in_seq_next       = in_seq;
    seq_mode_next     = seq_mode;
    err_next          = err;
    free_index_next   = free_index;
    root_links_next   = root_links;
    code_next         = code_q;
    last_next         = last_q;
    cur_k_next        = cur_k;
    parent_links_next = parent_links;
    parent_addr_next  = parent_addr;
    out_valid_next    = out_valid && !out_ready;
    out_item_next     = out_item;
    ram_we            = 1'b0;
    ram_waddr         = walk;
    ram_wdata         = '0;
    ram_raddr         = walk;
    fin_fire          = 1'b0;
    seq_open          = 1'b0;
    mode_eff          = MODE_INSERT;
    walk_eff          = '0;
    mism_eff          = 1'b0;
    alive_eff         = 3'b000;
    err_eff           = STATUS_OK;
    sel               = 2'd0;
    kk                = 2'd0;

    case (state)
      S_IDLE: begin
      end

      S_INS: begin
        if (child != '0) begin
          walk_next  = child;
          state_next = S_FIN;
        end else if (free_index >= CW'(NODES)) begin
          err_next   = STATUS_FULL;
          state_next = S_FIN;
        end else begin
          // Clear the new node now; link it from the parent.
          ram_we          = 1'b1;
          ram_waddr       = free_index[AW-1:0];
          ram_wdata       = '0;
          free_index_next = free_index + CW'(1);
          walk_next       = free_index[AW-1:0];
          if (walk == '0) begin
            root_links_next[code_q] = free_index[AW-1:0];
            state_next              = S_FIN;
          end else begin
            parent_links_next         = links;
            parent_links_next[code_q] = free_index[AW-1:0];
            parent_addr_next          = walk;
            state_next                = S_INS_WR;
          end
        end
      end

      S_INS_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = parent_addr;
        ram_wdata  = parent_links;
        state_next = S_FIN;
      end

      S_SRCH: begin
        if (child != '0) begin
          walk_next = child;
        end else begin
          // First break: open the sibling branches if allowed.
          mismatch_next = 1'b1;
          alive_next    = 3'b000;
          if (allowance) begin
            for (int s = 0; s < 4; s++) begin
              if (2'(s) != code_q) begin
                branch_next[kk] = links[s];
                alive_next[kk]  = (links[s] != '0);
                kk              = kk + 2'd1;
              end
            end
          end
        end
        state_next = S_FIN;
      end

      S_BR: begin
        // Evaluate the branch read last cycle, issue the next one.
        if (rd_links[code_q] == '0) begin
          alive_next[cur_k] = 1'b0;
        end else begin
          branch_next[cur_k] = rd_links[code_q];
        end
        if (pending != 3'b000) begin
          sel               = first_set(pending);
          ram_raddr         = branch[sel];
          pending_next[sel] = 1'b0;
          cur_k_next        = sel;
        end else begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (!last_q || !out_valid || out_ready) begin
          fin_fire   = 1'b1;
          state_next = S_IDLE;
          if (last_q) begin
            out_valid_next           = 1'b1;
            out_item_next.found      = found_now;
            out_item_next.status     = err;
            out_item_next.nodes_used = nodes_wide[16:0];
            in_seq_next              = 1'b0;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (in_fire) begin
      code_next = bc.code;
      last_next = in_item.last;
      case (in_item.func)
        FUNC_CLEAR: begin
          // Drop the trie and any open sequence.
          free_index_next = '0;
          root_links_next = '0;
          walk_next       = '0;
          alive_next      = 3'b000;
          mismatch_next   = 1'b0;
          in_seq_next     = 1'b0;
          err_next        = STATUS_OK;
          state_next      = S_IDLE;
        end

        FUNC_INSERT, FUNC_SEARCH: begin
          seq_open  = in_seq_next;
          mode_eff  = seq_open ? seq_mode : (in_item.func == FUNC_SEARCH);
          walk_eff  = seq_open ? walk : '0;
          mism_eff  = seq_open ? mismatch : 1'b0;
          alive_eff = seq_open ? alive : 3'b000;
          err_eff   = seq_open ? err : STATUS_OK;
          if (!seq_open) begin
            in_seq_next   = 1'b1;
            seq_mode_next = mode_eff;
            walk_next     = '0;
            alive_next    = 3'b000;
            mismatch_next = 1'b0;
            err_next      = STATUS_OK;
            if (mode_eff == MODE_INSERT && free_index == '0) begin
              root_links_next = '0;
              free_index_next = CW'(1);
            end
          end
          if (err_eff != STATUS_OK) begin
            state_next = S_FIN;
          end else if (!bc.valid) begin
            err_next   = STATUS_INVALID;
            state_next = S_FIN;
          end else if (mode_eff == MODE_INSERT) begin
            ram_raddr  = walk_eff;
            state_next = S_INS;
          end else if (!mism_eff) begin
            ram_raddr  = walk_eff;
            state_next = S_SRCH;
          end else if (alive_eff != 3'b000) begin
            sel          = first_set(alive_eff);
            ram_raddr    = branch[sel];
            pending_next = alive_eff;
            pending_next[sel] = 1'b0;
            cur_k_next   = sel;
            state_next   = S_BR;
          end else begin
            state_next = S_FIN;
          end
        end

        default: begin
          // Unused selector: ignore the transfer.
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      walk       <= '0;
      branch     <= '0;
      alive      <= 3'b000;
      pending    <= 3'b000;
      mismatch   <= 1'b0;
      in_seq     <= 1'b0;
      seq_mode   <= MODE_INSERT;
      err        <= STATUS_OK;
      free_index <= '0;
      root_links <= '0;
      allowance  <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      walk       <= walk_next;
      branch     <= branch_next;
      alive      <= alive_next;
      pending    <= pending_next;
      mismatch   <= mismatch_next;
      in_seq     <= in_seq_next;
      seq_mode   <= seq_mode_next;
      err        <= err_next;
      free_index <= free_index_next;
      root_links <= root_links_next;
      out_valid  <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        allowance <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    code_q       <= code_next;
    last_q       <= last_next;
    cur_k        <= cur_k_next;
    parent_links <= parent_links_next;
    parent_addr  <= parent_addr_next;
    out_item     <= out_item_next;
  end

  // Allocation never runs past the store.
  a_free_bound : assert property (@(posedge clk) disable iff (rst)
    free_index <= CW'(NODES))
    else $error("allocation count exceeds node store depth");

  // Branch reads are only queued while the branch walk runs.
  a_pending_br : assert property (@(posedge clk) disable iff (rst)
    (state != S_BR) |-> (pending == 3'b000))
    else $error("branch reads pending outside branch walk");

  // A live branch never points at the root.
  a_branch_nonroot : assert property (@(posedge clk) disable iff (rst)
    (!alive[0] || branch[0] != '0) && (!alive[1] || branch[1] != '0) &&
    (!alive[2] || branch[2] != '0))
    else $error("live branch cursor points at root");

  // A hit is only reported with a clean status.
  a_found_ok : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_item.found || out_item.status == STATUS_OK))
    else $error("found reported with error status");

  // A new result comes only from a finished last base.
  a_result_src : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN && last_q))
    else $error("result raised without a finished last base");

endmodule

/* tb/sv/trie_check_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trie_check_pkg
// Result predictor and scoreboard for the nucleotide trie block: mirrors the
// node store and walk state, queues the result each last base yields and
// compares what the block returns against it.
// ----------------------------------------------------------------------------
package trie_check_pkg;
  import dtrie_pkg::*;

  // Selector value that the block ignores
  localparam logic [1:0] FUNC_IGNORED = 2'd3;

  class trie_scoreboard #(int unsigned NODE_COUNT = 128);
    logic [15:0] kids [NODE_COUNT][4];
    logic [16:0] next_free;
    logic [15:0] cursor;
    logic [15:0] alt_cursor [3];
    logic [2:0]  alt_live;
    logic        slipped;
    logic        open_seq;
    logic        search_mode;
    logic [1:0]  seq_status;
    logic        allowance;
    out_item_t   due [$];
    int          mismatches;

    function new();
      clear_node(0);
      next_free   = '0;
      cursor      = '0;
      for (int k = 0; k < 3; k++) alt_cursor[k] = '0;
      alt_live    = '0;
      slipped     = 1'b0;
      open_seq    = 1'b0;
      search_mode = MODE_INSERT;
      seq_status  = STATUS_OK;
      allowance   = 1'b1;
      mismatches  = 0;
    endfunction

    function void clear_node(input logic [15:0] n);
      for (int s = 0; s < 4; s++) kids[n][s] = '0;
    endfunction

    function int slot_of(input logic [7:0] ch);
      case (ch)
        CHAR_A:  return 0;
        CHAR_C:  return 1;
        CHAR_G:  return 2;
        CHAR_T:  return 3;
        default: return -1;
      endcase
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_failure(input string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] %s", $time, what);
    endfunction

    // Follow or allocate the child for one inserted base.
    function void insert_step(input int b);
      logic [15:0] nxt;
      nxt = kids[cursor][b];
      if (nxt == '0) begin
        if (next_free >= NODE_COUNT) begin
          seq_status = STATUS_FULL;
          return;
        end
        nxt = next_free[15:0];
        clear_node(nxt);
        kids[cursor][b] = nxt;
        next_free++;
      end
      cursor = nxt;
    endfunction

    // Exact walk until the first break, then walk the surviving siblings.
    function void search_step(input int b);
      logic [15:0] nxt;
      int k;
      if (!slipped) begin
        nxt = kids[cursor][b];
        if (nxt != '0) begin
          cursor = nxt;
          return;
        end
        slipped  = 1'b1;
        alt_live = '0;
        if (allowance) begin
          k = 0;
          for (int s = 0; s < 4; s++) begin
            if (s != b) begin
              alt_cursor[k] = kids[cursor][s];
              if (alt_cursor[k] != '0) alt_live[k] = 1'b1;
              k++;
            end
          end
        end
        return;
      end
      for (k = 0; k < 3; k++) begin
        if (alt_live[k]) begin
          nxt = kids[alt_cursor[k]][b];
          if (nxt == '0) alt_live[k] = 1'b0;
          else alt_cursor[k] = nxt;
        end
      end
    endfunction

    // Apply one accepted input and queue the result it yields, if any.
    function void note_input(input in_item_t it);
      out_item_t r;
      int b;
      if (it.func == FUNC_IGNORED) return;
      if (it.func == FUNC_CLEAR) begin
        next_free  = '0;
        clear_node(0);
        cursor     = '0;
        alt_live   = '0;
        slipped    = 1'b0;
        open_seq   = 1'b0;
        seq_status = STATUS_OK;
        return;
      end
      if (!open_seq) begin
        open_seq    = 1'b1;
        search_mode = (it.func == FUNC_SEARCH) ? MODE_SEARCH : MODE_INSERT;
        cursor      = '0;
        alt_live    = '0;
        slipped     = 1'b0;
        seq_status  = STATUS_OK;
        if (search_mode == MODE_INSERT && next_free == '0) begin
          clear_node(0);
          next_free = 17'd1;
        end
      end
      if (seq_status == STATUS_OK) begin
        b = slot_of(it.base_char);
        if (b < 0) seq_status = STATUS_INVALID;
        else if (search_mode == MODE_INSERT) insert_step(b);
        else search_step(b);
      end
      if (!it.last) return;
      r.found      = (search_mode == MODE_SEARCH) && (seq_status == STATUS_OK) &&
                     (!slipped || alt_live != '0);
      r.status     = seq_status;
      r.nodes_used = next_free;
      due.push_back(r);
      open_seq = 1'b0;
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        note_failure($sformatf("result with nothing expected: found=%0b status=%0d nodes=%0d",
                               got.found, got.status, got.nodes_used));
        return;
      end
      want = due.pop_front();
      if (got.found !== want.found || got.status !== want.status ||
          got.nodes_used !== want.nodes_used)
        note_failure($sformatf({"result mismatch: expected found=%0b status=%0d nodes=%0d,",
                                " got found=%0b status=%0d nodes=%0d"},
                               want.found, want.status, want.nodes_used,
                               got.found, got.status, got.nodes_used));
    endfunction
  endclass

endpackage

/* tb/sv/dna_trie_insert_and_fuzzy_search_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dna_trie_insert_and_fuzzy_search_test
// Drives base streams of insert, search, clear and ignored items into the
// trie block, predicts each sequence result and checks it on the way out,
// under both mismatch allowances and several input and output idle mixes.
// ----------------------------------------------------------------------------
module dna_trie_insert_and_fuzzy_search_test;
  import dtrie_pkg::*;
  import trie_check_pkg::*;

  // A small store so that full-store exits come up in a short run
  localparam int TRIE_NODES    = 128;
  localparam int MAX_LEN       = 16;
  localparam int LIB_DEPTH     = 32;
  localparam int PHASE_ITEMS   = 380;
  // Leave ample room for in-flight work
  localparam int SETTLE_CYCLES = 24;
  // Long output hold used to back the block up into its input
  localparam int HOLD_CYCLES   = 300;
  // Cycles without any transfer before the run is declared hung; well above
  // the output hold plus the slowest base under the heaviest idling
  localparam int STALL_LIMIT   = 3000;

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_ready;
  logic      out_valid;
  logic      cfg_ready;
  out_item_t out_item;

  trie_scoreboard #(TRIE_NODES) sb;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  // Count of long output holds asked for; the output process tracks its own
  int   hold_req      = 0;
  int   items_sent    = 0;

  // Sequence under construction and a ring of recently inserted sequences
  logic [7:0] cur_seq [MAX_LEN];
  logic [7:0] lib_seq [LIB_DEPTH][MAX_LEN];
  int         lib_len [LIB_DEPTH];
  int         lib_count = 0;
  int         lib_wr    = 0;

  dna_trie_insert_and_fuzzy_search #(
    .NODES(TRIE_NODES)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic in_item_t base_item(input logic [1:0] fn, input logic [7:0] ch,
                                         input logic lst);
    in_item_t it;
    it.func      = fn;
    it.base_char = ch;
    it.last      = lst;
    return it;
  endfunction

  function automatic logic [7:0] any_base();
    case ($urandom_range(3))
      0:       return CHAR_A;
      1:       return CHAR_C;
      2:       return CHAR_G;
      default: return CHAR_T;
    endcase
  endfunction

  // Offer one item and hold it until the transfer. Valid is left high so a
  // back-to-back item follows without a drop; a gap lowers it first.
  task automatic push_base(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    if (it.func != FUNC_IGNORED) items_sent++;
  endtask

  task automatic send_seq(input logic [1:0] fn, input int len);
    for (int i = 0; i < len; i++) push_base(base_item(fn, cur_seq[i], i == len - 1));
  endtask

  task automatic send_text(input logic [1:0] fn, input string s);
    for (int i = 0; i < s.len(); i++) cur_seq[i] = s[i];
    send_seq(fn, s.len());
  endtask

  // Drop valid and wait for every expected result, then let trailing
  // result-free work finish inside the block.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_allowance(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.allowance = v;
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed inserts and searches of stored sequences with a few
  // substitutions, mixed with clears, ignored items and broken sequences.
  task automatic run_random(input int budget);
    int goal;
    int pick;
    int v;
    int len;
    int idx;
    int pos;
    int subs;
    int bad;
    logic [7:0] ch;
    logic [1:0] fn;
    goal = items_sent + budget;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        // fresh insert, occasionally deep
        len = ($urandom_range(19) == 0) ? $urandom_range(9, MAX_LEN) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          cur_seq[i] = any_base();
          lib_seq[lib_wr][i] = cur_seq[i];
        end
        lib_len[lib_wr] = len;
        lib_wr = (lib_wr + 1) % LIB_DEPTH;
        if (lib_count < LIB_DEPTH) lib_count++;
        send_seq(FUNC_INSERT, len);
      end else if (pick < 70 && lib_count > 0) begin
        // search a stored sequence: exact, substituted, cut short or extended
        idx = $urandom_range(lib_count - 1);
        len = lib_len[idx];
        for (int i = 0; i < len; i++) cur_seq[i] = lib_seq[idx][i];
        v = $urandom_range(99);
        if (v >= 85 && v < 95) begin
          len = $urandom_range(1, len);
        end else if (v >= 95 && len < MAX_LEN) begin
          cur_seq[len] = any_base();
          len++;
        end
        subs = (v < 45) ? 0 : (v < 75) ? 1 : (v < 85) ? 2 : 0;
        for (int j = 0; j < subs; j++) begin
          pos = $urandom_range(len - 1);
          do ch = any_base(); while (ch == cur_seq[pos]);
          cur_seq[pos] = ch;
        end
        send_seq(FUNC_SEARCH, len);
      end else if (pick < 80) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) cur_seq[i] = any_base();
        send_seq(FUNC_SEARCH, len);
      end else if (pick < 84) begin
        push_base(base_item(FUNC_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1))));
        lib_count = 0;
      end else if (pick < 89) begin
        push_base(base_item(FUNC_IGNORED, 8'($urandom_range(255)), 1'($urandom_range(1))));
      end else if (pick < 96) begin
        // selector flips mid-sequence and one arbitrary byte somewhere
        len = $urandom_range(1, 6);
        bad = $urandom_range(len - 1);
        for (int i = 0; i < len; i++) begin
          fn = $urandom_range(1) ? FUNC_SEARCH : FUNC_INSERT;
          ch = (i == bad) ? 8'($urandom_range(255)) : any_base();
          push_base(base_item(fn, ch, i == len - 1));
        end
      end else begin
        // abandon an open sequence with a clear
        len = $urandom_range(1, 5);
        fn  = $urandom_range(1) ? FUNC_SEARCH : FUNC_INSERT;
        for (int i = 0; i < len; i++) push_base(base_item(fn, any_base(), 1'b0));
        push_base(base_item(FUNC_CLEAR, any_base(), 1'($urandom_range(1))));
        lib_count = 0;
      end
    end
  endtask

  // Output side: check each transfer, then pick the next ready level. A
  // requested hold keeps ready low until its HOLD_CYCLES countdown runs out.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_item);
      if (hold_req != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_req;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset allowance of one, empty-trie search, exact hit,
    // mid-path and last-base substitutions, invalid bytes at both ends of
    // the byte range, an ignored item and a clear that carries last.
    send_text(FUNC_SEARCH, "A");
    send_text(FUNC_INSERT, "ACGT");
    send_text(FUNC_SEARCH, "ACGT");
    send_text(FUNC_SEARCH, "ACTT");
    send_text(FUNC_SEARCH, "ACGA");
    cur_seq[0] = CHAR_A;
    cur_seq[1] = 8'h00;
    cur_seq[2] = CHAR_G;
    send_seq(FUNC_INSERT, 3);
    push_base(base_item(FUNC_SEARCH, 8'hFF, 1'b1));
    push_base(base_item(FUNC_IGNORED, 8'hAA, 1'b1));
    push_base(base_item(FUNC_CLEAR, CHAR_T, 1'b1));
    send_text(FUNC_SEARCH, "A");
    settle();

    // Sender idles often, receiver more so
    send_idle_pct = 34;
    recv_idle_pct = 60;
    write_allowance(1'b0);
    run_random(PHASE_ITEMS);
    settle();

    // Roles swapped; pause the sender halfway until all results are back
    send_idle_pct = 60;
    recv_idle_pct = 34;
    write_allowance(1'b1);
    run_random(PHASE_ITEMS / 2);
    settle();
    run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    settle();

    // No idling; hold the output off at the start so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_allowance(1'b0);
    hold_req++;
    run_random(PHASE_ITEMS);
    settle();

    write_allowance(1'b1);
    run_random(PHASE_ITEMS);
    settle();

    if (sb.pending() != 0)
      sb.note_failure($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
